// ===== rtl/ipv6_prefix_table_lpm_core_assert.svh =====
// Assertion helpers for the prefix table core.
`ifndef IPV6_PREFIX_TABLE_LPM_CORE_ASSERT_SVH
`define IPV6_PREFIX_TABLE_LPM_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define IPT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define IPT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/ipv6lpm_pkg.sv =====
`timescale 1ns / 1ps

package ipv6lpm_pkg;

  localparam int STORE_ENTRIES = 1024;
  localparam int TABLE_COUNT   = 256;
  localparam int IDX_W         = $clog2(STORE_ENTRIES);
  localparam int MAX_LEN       = 128;

  localparam int IN_DATA_W  = 176;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 3;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LPM    = 2'd2,
    ACT_EXACT  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [7:0]  tbl;
    logic [63:0] pfx_hi;
    logic [63:0] pfx_lo;
    logic [7:0]  len;
    logic [31:0] value;
  } entry_t;

  // Top len bits of the upper address half.
  function automatic logic [63:0] mask_hi(input logic [7:0] len);
    logic [63:0] m;
    if (len >= 8'd64) begin
      m = {64{1'b1}};
    end else begin
      m = ~({64{1'b1}} >> len);
    end
    return m;
  endfunction

  // Top (len - 64) bits of the lower address half.
  function automatic logic [63:0] mask_lo(input logic [7:0] len);
    logic [63:0] m;
    if (len <= 8'd64) begin
      m = '0;
    end else if (len >= 8'd128) begin
      m = {64{1'b1}};
    end else begin
      m = ~({64{1'b1}} >> (len - 8'd64));
    end
    return m;
  endfunction

endpackage

// ===== rtl/ipv6_prefix_table_lpm_core.sv =====
`timescale 1ns / 1ps
// Port    Dir  Fields, low bit up
// s_axis  in   tuser: action; tdata: route_tbl, addr_hi, addr_lo, prefix_len, entry_value
// m_axis  out  tuser: found, status; tdata: result_value
//
// Each word passes through accept, a scan that reads one slot per cycle through
// the single read port of the slot RAM, a drain step, and a finish step that
// writes back and loads the result register.
// After reset a clearing pass writes every slot invalid, with s_axis_tready
// low. A stalled m_axis holds the core in its last step; the next word is still
// accepted while a result waits.

`include "ipv6_prefix_table_lpm_core_assert.svh"

module ipv6_prefix_table_lpm_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // route_tbl, addr_hi, addr_lo, prefix_len, entry_value
  input  logic [ipv6lpm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // action
  input  logic [ipv6lpm_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // result_value
  output logic [ipv6lpm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // found, status
  output logic [ipv6lpm_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

  localparam int IdxW = ipv6lpm_pkg::IDX_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ipv6lpm_pkg::STORE_ENTRIES - 1);

  ipv6lpm_pkg::state_e state_q, state_d;

  logic [IdxW-1:0] addr_q, addr_d;
  logic            addr_last;

  // request registers
  ipv6lpm_pkg::action_e act_q;
  logic [7:0]           tbl_q;
  logic [63:0]          ahi_q, alo_q, khi_q, klo_q;
  logic [7:0]           klen_q;
  logic [31:0]          val_q;

  logic        in_accept;
  logic [7:0]  in_len, in_len_sat, in_tbl;

  // slot RAM
  ipv6lpm_pkg::entry_t mem [ipv6lpm_pkg::STORE_ENTRIES];
  ipv6lpm_pkg::entry_t rd_q;
  ipv6lpm_pkg::entry_t mem_wdata;
  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;

  logic            eval_v_q;
  logic [IdxW-1:0] eval_idx_q;

  // scan results
  logic            exact_hit_q, free_hit_q, best_hit_q;
  logic [IdxW-1:0] exact_idx_q, free_idx_q;
  logic [31:0]     exact_val_q, best_val_q;
  logic [7:0]      best_len_q;

  logic ex_match, lpm_match;

  // result decode
  logic                 res_found;
  logic [31:0]          res_value;
  ipv6lpm_pkg::status_e res_status;
  logic                 res_wr;
  logic                 res_wr_valid;
  logic [IdxW-1:0]      res_waddr;

  logic        out_free, out_load;
  logic        m_valid_q;
  logic [31:0] m_data_q;
  logic [2:0]  m_user_q;

  assign addr_last = (addr_q == LastIdx);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_len    = s_axis_tdata[143:136];
  assign in_len_sat = (in_len > 8'(ipv6lpm_pkg::MAX_LEN)) ? 8'(ipv6lpm_pkg::MAX_LEN) : in_len;
  assign in_tbl    = 8'({1'b0, s_axis_tdata[7:0]} % 9'(ipv6lpm_pkg::TABLE_COUNT));

  assign out_free = !m_valid_q || m_axis_tready;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ipv6lpm_pkg::S_CLEAR:  if (addr_last) state_d = ipv6lpm_pkg::S_IDLE;
      ipv6lpm_pkg::S_IDLE:   if (in_accept) state_d = ipv6lpm_pkg::S_SCAN;
      ipv6lpm_pkg::S_SCAN:   if (addr_last) state_d = ipv6lpm_pkg::S_DRAIN;
      ipv6lpm_pkg::S_DRAIN:  state_d = ipv6lpm_pkg::S_FINISH;
      ipv6lpm_pkg::S_FINISH: if (out_free) state_d = ipv6lpm_pkg::S_IDLE;
      default:               state_d = ipv6lpm_pkg::S_CLEAR;
    endcase
  end

  // ---------------- state outputs ----------------
  always_comb begin
    s_axis_tready = 1'b0;
    addr_d        = '0;
    mem_we        = 1'b0;
    mem_waddr     = addr_q;
    mem_wdata     = '0;
    out_load      = 1'b0;
    unique case (state_q)
      ipv6lpm_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        addr_d = addr_last ? '0 : addr_q + 1'b1;
      end
      ipv6lpm_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ipv6lpm_pkg::S_SCAN: begin
        addr_d = addr_last ? '0 : addr_q + 1'b1;
      end
      ipv6lpm_pkg::S_DRAIN: begin
      end
      ipv6lpm_pkg::S_FINISH: begin
        out_load  = out_free;
        mem_we    = out_free && res_wr;
        mem_waddr = res_waddr;
        if (res_wr_valid) begin
          mem_wdata = '{valid: 1'b1, tbl: tbl_q, pfx_hi: khi_q, pfx_lo: klo_q,
                        len: klen_q, value: val_q};
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- result decode ----------------
  always_comb begin
    res_found    = 1'b0;
    res_value    = '0;
    res_status   = ipv6lpm_pkg::ST_OK;
    res_wr       = 1'b0;
    res_wr_valid = 1'b0;
    res_waddr    = exact_idx_q;
    case (act_q)
      ipv6lpm_pkg::ACT_INSERT: begin
        res_waddr = free_idx_q;
        if (exact_hit_q) begin
          res_status = ipv6lpm_pkg::ST_DUP;
        end else if (free_hit_q) begin
          res_wr       = 1'b1;
          res_wr_valid = 1'b1;
        end else begin
          res_status = ipv6lpm_pkg::ST_FULL;
        end
      end
      ipv6lpm_pkg::ACT_REMOVE: begin
        if (exact_hit_q) res_wr = 1'b1;
        else             res_status = ipv6lpm_pkg::ST_ABSENT;
      end
      ipv6lpm_pkg::ACT_EXACT: begin
        res_found = exact_hit_q;
        if (exact_hit_q) res_value = exact_val_q;
        else             res_status = ipv6lpm_pkg::ST_ABSENT;
      end
      default: begin
        res_found = best_hit_q;
        if (best_hit_q) res_value = best_val_q;
        else            res_status = ipv6lpm_pkg::ST_ABSENT;
      end
    endcase
  end

  // ---------------- per-slot compare ----------------
  always_comb begin
    ex_match = rd_q.valid && (rd_q.tbl == tbl_q) && (rd_q.len == klen_q) &&
               (rd_q.pfx_hi == khi_q) && (rd_q.pfx_lo == klo_q);
    lpm_match = rd_q.valid && (rd_q.tbl == tbl_q) && (rd_q.len <= klen_q) &&
                ((ahi_q & ipv6lpm_pkg::mask_hi(rd_q.len)) == rd_q.pfx_hi) &&
                ((alo_q & ipv6lpm_pkg::mask_lo(rd_q.len)) == rd_q.pfx_lo);
  end

  // ---------------- slot RAM ----------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[addr_q];
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ipv6lpm_pkg::S_CLEAR;
      addr_q     <= '0;
      eval_v_q   <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      eval_v_q <= (state_q == ipv6lpm_pkg::S_SCAN);
      if (out_load)           m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exact_hit_q <= 1'b0;
      free_hit_q  <= 1'b0;
      best_hit_q  <= 1'b0;
    end else if (in_accept) begin
      exact_hit_q <= 1'b0;
      free_hit_q  <= 1'b0;
      best_hit_q  <= 1'b0;
    end else if (eval_v_q) begin
      if (ex_match && !exact_hit_q) exact_hit_q <= 1'b1;
      if (!rd_q.valid && !free_hit_q) free_hit_q <= 1'b1;
      if (lpm_match) best_hit_q <= 1'b1;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    eval_idx_q <= addr_q;
    if (in_accept) begin
      act_q  <= ipv6lpm_pkg::action_e'(s_axis_tuser);
      tbl_q  <= in_tbl;
      ahi_q  <= s_axis_tdata[71:8];
      alo_q  <= s_axis_tdata[135:72];
      khi_q  <= s_axis_tdata[71:8] & ipv6lpm_pkg::mask_hi(in_len_sat);
      klo_q  <= s_axis_tdata[135:72] & ipv6lpm_pkg::mask_lo(in_len_sat);
      klen_q <= in_len_sat;
      val_q  <= s_axis_tdata[175:144];
    end
    if (eval_v_q) begin
      if (ex_match && !exact_hit_q) begin
        exact_idx_q <= eval_idx_q;
        exact_val_q <= rd_q.value;
      end
      if (!rd_q.valid && !free_hit_q) begin
        free_idx_q <= eval_idx_q;
      end
      // strictly longer wins, so the lowest slot keeps a tie
      if (lpm_match && (!best_hit_q || rd_q.len > best_len_q)) begin
        best_len_q <= rd_q.len;
        best_val_q <= rd_q.value;
      end
    end
    if (out_load) begin
      m_data_q <= res_value;
      m_user_q <= {res_status, res_found};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // ---------------- assertions ----------------
  `IPT_ASSERT(a_we_state, clk_i, rst_ni,
      mem_we |-> (state_q == ipv6lpm_pkg::S_CLEAR || state_q == ipv6lpm_pkg::S_FINISH),
      "slot RAM written outside clear or finish")
  `IPT_ASSERT(a_ins_free, clk_i, rst_ni,
      (mem_we && mem_wdata.valid) |-> (free_hit_q && !exact_hit_q),
      "insert written without a free slot or over a duplicate")
  `IPT_ASSERT(a_accept_scan, clk_i, rst_ni,
      in_accept |=> (state_q == ipv6lpm_pkg::S_SCAN),
      "accepted word did not start a scan")
  `IPT_ASSERT(a_out_src, clk_i, rst_ni,
      $rose(m_axis_tvalid) |-> $past(state_q) == ipv6lpm_pkg::S_FINISH,
      "result raised outside finish")
  `IPT_NEVER(a_found_status, clk_i, rst_ni,
      m_axis_tvalid && m_axis_tuser[0] && (m_axis_tuser[2:1] != ipv6lpm_pkg::ST_OK),
      "found result with error status")

endmodule

// ===== test/ipv6_prefix_table_lpm_core_tb.sv =====
`timescale 1ns / 1ps

module ipv6_prefix_table_lpm_core_tb;

  localparam int unsigned RANDOM_ITEMS = 556;
  localparam int unsigned HOLD_CYCLES  = 6000;
  localparam int unsigned DRAIN_CYCLES = 1100;
  localparam int unsigned CYCLE_LIMIT  = 6000000;

  localparam logic [63:0] NET_HI = 64'h2001_0db8_85a3_0000;
  localparam logic [63:0] NET_LO = 64'h0000_8a2e_0370_7334;

  typedef struct {
    ipv6lpm_pkg::action_e act;
    logic [7:0]           tbl;
    logic [63:0]          hi;
    logic [63:0]          lo;
    logic [7:0]           plen;
    logic [31:0]          val;
  } route_req_t;

  typedef struct {
    logic                 found;
    logic [31:0]          value;
    ipv6lpm_pkg::status_e status;
  } route_rsp_t;

  class route_scoreboard;
    bit          live      [ipv6lpm_pkg::STORE_ENTRIES];
    logic [7:0]  key_tbl   [ipv6lpm_pkg::STORE_ENTRIES];
    logic [63:0] key_hi    [ipv6lpm_pkg::STORE_ENTRIES];
    logic [63:0] key_lo    [ipv6lpm_pkg::STORE_ENTRIES];
    int unsigned key_len   [ipv6lpm_pkg::STORE_ENTRIES];
    logic [31:0] route_val [ipv6lpm_pkg::STORE_ENTRIES];
    route_rsp_t  pending_rsp [$];
    int unsigned errors = 0;

    // Top bits kept by a prefix of length n (0..128), per address half.
    static function logic [63:0] keep_upper(int unsigned n);
      if (n == 0) return 64'd0;
      if (n >= 64) return ~64'd0;
      return ~64'd0 << (64 - n);
    endfunction

    static function logic [63:0] keep_lower(int unsigned n);
      if (n <= 64) return 64'd0;
      if (n >= 128) return ~64'd0;
      return ~64'd0 << (128 - n);
    endfunction

    function int find_key(logic [7:0] t, logic [63:0] h, logic [63:0] l, int unsigned n);
      for (int i = 0; i < ipv6lpm_pkg::STORE_ENTRIES; i++) begin
        if (live[i] && key_tbl[i] == t && key_len[i] == n && key_hi[i] == h &&
            key_lo[i] == l)
          return i;
      end
      return -1;
    endfunction

    function int free_slot();
      for (int i = 0; i < ipv6lpm_pkg::STORE_ENTRIES; i++) begin
        if (!live[i]) return i;
      end
      return -1;
    endfunction

    // Apply one accepted word to the route store and queue its response.
    function void accept_request(route_req_t r);
      int unsigned n;
      int unsigned best_len;
      logic [7:0]  t;
      logic [63:0] khi;
      logic [63:0] klo;
      int          slot;
      int          best;
      route_rsp_t  e;
      n = (r.plen > 8'd128) ? 128 : r.plen;
      t = 8'(int'(r.tbl) % ipv6lpm_pkg::TABLE_COUNT);
      khi = r.hi & keep_upper(n);
      klo = r.lo & keep_lower(n);
      e.found = 1'b0;
      e.value = '0;
      e.status = ipv6lpm_pkg::ST_OK;
      case (r.act)
        ipv6lpm_pkg::ACT_INSERT: begin
          if (find_key(t, khi, klo, n) >= 0) begin
            e.status = ipv6lpm_pkg::ST_DUP;
          end else begin
            slot = free_slot();
            if (slot < 0) begin
              e.status = ipv6lpm_pkg::ST_FULL;
            end else begin
              live[slot] = 1'b1;
              key_tbl[slot] = t;
              key_hi[slot] = khi;
              key_lo[slot] = klo;
              key_len[slot] = n;
              route_val[slot] = r.val;
            end
          end
        end
        ipv6lpm_pkg::ACT_REMOVE: begin
          slot = find_key(t, khi, klo, n);
          if (slot >= 0) live[slot] = 1'b0;
          else e.status = ipv6lpm_pkg::ST_ABSENT;
        end
        ipv6lpm_pkg::ACT_EXACT: begin
          slot = find_key(t, khi, klo, n);
          if (slot >= 0) begin
            e.found = 1'b1;
            e.value = route_val[slot];
          end else begin
            e.status = ipv6lpm_pkg::ST_ABSENT;
          end
        end
        default: begin
          best = -1;
          best_len = 0;
          for (int i = 0; i < ipv6lpm_pkg::STORE_ENTRIES; i++) begin
            if (live[i] && key_tbl[i] == t && key_len[i] <= n &&
                (r.hi & keep_upper(key_len[i])) == key_hi[i] &&
                (r.lo & keep_lower(key_len[i])) == key_lo[i] &&
                (best < 0 || key_len[i] > best_len)) begin
              best = i;
              best_len = key_len[i];
            end
          end
          if (best >= 0) begin
            e.found = 1'b1;
            e.value = route_val[best];
          end else begin
            e.status = ipv6lpm_pkg::ST_ABSENT;
          end
        end
      endcase
      pending_rsp.push_back(e);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_response(logic found, logic [31:0] value, logic [1:0] status);
      route_rsp_t e;
      if (pending_rsp.size() == 0) begin
        report($sformatf("unexpected word found=%b value=%h status=%0d",
                         found, value, status));
      end else begin
        e = pending_rsp.pop_front();
        if (found !== e.found || value !== e.value || status !== e.status)
          report($sformatf("found %b exp %b, value %h exp %h, status %0d exp %0d",
                           found, e.found, value, e.value, status, e.status));
      end
    endtask
  endclass

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [ipv6lpm_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [ipv6lpm_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [ipv6lpm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [ipv6lpm_pkg::OUT_USER_W-1:0] m_axis_tuser;

  route_scoreboard route_sb = new();

  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned rx_gap;
  int unsigned cycle_count;

  logic [7:0]  pool_tbl [4];
  logic [63:0] pool_hi [6];
  logic [63:0] pool_lo [6];
  route_req_t  insert_history [$];

  ipv6_prefix_table_lpm_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic route_req_t mk_req(ipv6lpm_pkg::action_e a, logic [7:0] t,
                                        logic [63:0] h, logic [63:0] l, logic [7:0] n,
                                        logic [31:0] v);
    route_req_t r;
    r.act = a;
    r.tbl = t;
    r.hi = h;
    r.lo = l;
    r.plen = n;
    r.val = v;
    return r;
  endfunction

  // Mostly well-formed traffic around a few tables and base prefixes so
  // lookups hit, with some fully random noise mixed in.
  function automatic route_req_t random_req();
    route_req_t  r;
    route_req_t  h;
    int unsigned roll;
    int unsigned k;
    int unsigned b;
    logic [63:0] kh;
    logic [63:0] kl;
    roll = $urandom_range(0, 99);
    b = $urandom_range(0, 5);
    k = $urandom_range(0, 128);
    kh = route_scoreboard::keep_upper(k);
    kl = route_scoreboard::keep_lower(k);
    r.tbl = pool_tbl[$urandom_range(0, 3)];
    r.hi = (pool_hi[b] & kh) | ({$urandom, $urandom} & ~kh);
    r.lo = (pool_lo[b] & kl) | ({$urandom, $urandom} & ~kl);
    r.plen = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(129, 255))
                                          : 8'($urandom_range(0, 128));
    r.val = $urandom;
    if (roll < 35) r.act = ipv6lpm_pkg::ACT_INSERT;
    else if (roll < 50) r.act = ipv6lpm_pkg::ACT_REMOVE;
    else if (roll < 78) r.act = ipv6lpm_pkg::ACT_LPM;
    else if (roll < 92) r.act = ipv6lpm_pkg::ACT_EXACT;
    else begin
      r.act = ipv6lpm_pkg::action_e'($urandom_range(0, 3));
      r.tbl = 8'($urandom);
      r.hi = {$urandom, $urandom};
      r.lo = {$urandom, $urandom};
      r.plen = 8'($urandom);
    end
    if ((r.act == ipv6lpm_pkg::ACT_REMOVE || r.act == ipv6lpm_pkg::ACT_EXACT) &&
        insert_history.size() > 0 && $urandom_range(0, 9) < 7) begin
      h = insert_history[$urandom_range(0, insert_history.size() - 1)];
      r.tbl = h.tbl;
      r.hi = h.hi;
      r.lo = h.lo;
      r.plen = h.plen;
    end
    if (r.act == ipv6lpm_pkg::ACT_INSERT) begin
      insert_history.push_back(r);
      if (insert_history.size() > 64) void'(insert_history.pop_front());
    end
    return r;
  endfunction

  task automatic send_req(route_req_t r);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r.val, r.plen, r.lo, r.hi, r.tbl};
    s_axis_tuser <= r.act;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    route_sb.accept_request(r);
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
  endtask

  // Response side; one long hold-off on request so the core backs up.
  initial begin
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        rx_gap = rx_steady ? 0 : $urandom_range(0, 8);
        if (rx_gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (rx_gap) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      route_sb.check_response(m_axis_tuser[0], m_axis_tdata, m_axis_tuser[2:1]);
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty store, default route, saturated length, nested prefixes
    send_req(mk_req(ipv6lpm_pkg::ACT_LPM,    8'd0,   NET_HI, NET_LO, 8'd128, 32'd0));
    send_req(mk_req(ipv6lpm_pkg::ACT_INSERT, 8'd0,   64'd0,  64'd0,  8'd0,   32'd0));
    send_req(mk_req(ipv6lpm_pkg::ACT_INSERT, 8'd0,   '1,     '1,     8'd0,   32'h1111));
    send_req(mk_req(ipv6lpm_pkg::ACT_INSERT, 8'd255, '1,     '1,     8'd128, '1));
    send_req(mk_req(ipv6lpm_pkg::ACT_INSERT, 8'd255, '1,     '1,     8'd255, 32'h5));
    send_req(mk_req(ipv6lpm_pkg::ACT_EXACT,  8'd255, '1,     '1,     8'd200, 32'd0));
    send_req(mk_req(ipv6lpm_pkg::ACT_INSERT, 8'd0,   NET_HI, NET_LO, 8'd32,  32'd1));
    send_req(mk_req(ipv6lpm_pkg::ACT_INSERT, 8'd0,   NET_HI, NET_LO, 8'd48,  32'd2));
    send_req(mk_req(ipv6lpm_pkg::ACT_INSERT, 8'd0,   NET_HI, NET_LO, 8'd64,  32'd3));
    send_req(mk_req(ipv6lpm_pkg::ACT_INSERT, 8'd0,   NET_HI, NET_LO, 8'd96,  32'd4));
    send_req(mk_req(ipv6lpm_pkg::ACT_INSERT, 8'd0,   NET_HI, NET_LO, 8'd65,  32'd6));
    send_req(mk_req(ipv6lpm_pkg::ACT_LPM,    8'd0,   NET_HI, NET_LO, 8'd128, 32'd0));
    send_req(mk_req(ipv6lpm_pkg::ACT_LPM,    8'd0,   NET_HI, NET_LO, 8'd50,  32'd0));
    send_req(mk_req(ipv6lpm_pkg::ACT_LPM,    8'd0,   NET_HI, NET_LO, 8'd31,  32'd0));
    send_req(mk_req(ipv6lpm_pkg::ACT_LPM,    8'd0,   NET_HI, ~NET_LO, 8'd128, 32'd0));
    send_req(mk_req(ipv6lpm_pkg::ACT_LPM,    8'd1,   NET_HI, NET_LO, 8'd128, 32'd0));
    send_req(mk_req(ipv6lpm_pkg::ACT_EXACT,  8'd0,   NET_HI, NET_LO, 8'd40,  32'd0));
    // host bits beyond the length must not matter
    send_req(mk_req(ipv6lpm_pkg::ACT_REMOVE, 8'd0,   NET_HI, '1,     8'd48,  32'd0));
    send_req(mk_req(ipv6lpm_pkg::ACT_REMOVE, 8'd0,   NET_HI, NET_LO, 8'd48,  32'd0));
    send_req(mk_req(ipv6lpm_pkg::ACT_LPM,    8'd0,   NET_HI, NET_LO, 8'd50,  32'd0));
    send_req(mk_req(ipv6lpm_pkg::ACT_INSERT, 8'd0,   NET_HI, NET_LO, 8'd48,  32'd7));
    send_req(mk_req(ipv6lpm_pkg::ACT_EXACT,  8'd0,   NET_HI, 64'd0,  8'd48,  32'd0));
    send_req(mk_req(ipv6lpm_pkg::ACT_REMOVE, 8'd0,   64'd0,  64'd0,  8'd0,   32'd0));
    send_req(mk_req(ipv6lpm_pkg::ACT_LPM,    8'd0,   ~NET_HI, 64'd0, 8'd128, 32'd0));

    pool_tbl[0] = 8'd0;
    pool_tbl[1] = 8'd255;
    pool_tbl[2] = 8'($urandom);
    pool_tbl[3] = 8'($urandom);
    pool_hi[0] = 64'd0;
    pool_lo[0] = 64'd0;
    pool_hi[1] = '1;
    pool_lo[1] = '1;
    pool_hi[2] = NET_HI;
    pool_lo[2] = NET_LO;
    for (int i = 3; i < 6; i++) begin
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 40) hold_req = 1'b1;
      send_req(random_req());
    end
    s_axis_tvalid <= 1'b0;

    while (route_sb.pending_rsp.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (route_sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
